@@ rtl/core/key_click_classifier_assert.svh @@
// Assertion macros shared by the key click classifier RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef KEY_CLICK_CLASSIFIER_ASSERT_SVH
`define KEY_CLICK_CLASSIFIER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define KCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("key click classifier: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define KCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("key click classifier: next-cycle check failed");

`endif

@@ rtl/core/kcc_pkg.sv @@
package kcc_pkg;

  typedef enum logic [2:0] {
    KS_IDLE     = 3'd0,
    KS_PRESSED  = 3'd1,
    KS_DCHECK   = 3'd2,
    KS_DCONFIRM = 3'd3,
    KS_LONG     = 3'd4
  } btn_state_t;

  // Event kinds carried on the input tuser.
  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TICK    = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMER_TOP   = 2'd0;
  localparam logic [1:0] REG_PERIOD_US   = 2'd1;
  localparam logic [1:0] REG_DOUBLE_TOUT = 2'd2;
  localparam logic [1:0] REG_LONG_TOUT   = 2'd3;

  localparam logic [15:0] TIMER_TOP_RST   = 16'd999;
  localparam logic [15:0] PERIOD_US_RST   = 16'd1000;
  localparam logic [31:0] DOUBLE_TOUT_RST = 32'd500000;
  localparam logic [31:0] LONG_TOUT_RST   = 32'd3000000;

  typedef struct packed {
    logic [15:0] timer_top;
    logic [15:0] period_us;
    logic [31:0] double_timeout_us;
    logic [31:0] long_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [7:0] long_count;
    logic [7:0] double_count;
    logic [7:0] click_count;
    btn_state_t btn_state;
  } result_t;

endpackage

@@ rtl/core/kcc_fsm.sv @@
module kcc_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ev_en,
  input  logic [1:0]       ev_mode,
  input  logic [15:0]      ev_cap,
  input  kcc_pkg::cfg_t    cfg,
  output kcc_pkg::result_t res_nxt
);
  import kcc_pkg::*;

  btn_state_t  state_r, state_nxt;
  logic [31:0] gap_r, gap_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic [15:0] pcap_r, pcap_nxt;
  logic        pvalid_r, pvalid_nxt;
  logic [15:0] ovf_r, ovf_nxt;
  logic        startup_r, startup_nxt;
  logic [7:0]  click_r, click_nxt;
  logic [7:0]  dbl_r, dbl_nxt;
  logic [7:0]  lng_r, lng_nxt;

  logic [31:0] period32;
  logic [31:0] top32;
  logic [31:0] cap32;
  logic [31:0] p32;
  logic [15:0] ovf_m1;
  logic [31:0] ovf_time;
  logic [31:0] dur;
  logic [31:0] press_gap;
  logic [31:0] gap_tick;
  logic [31:0] hold_tick;

  assign period32  = {16'b0, cfg.period_us};
  assign top32     = {16'b0, cfg.timer_top};
  assign cap32     = {16'b0, ev_cap};
  // With no press recorded the press capture counts as minus one.
  assign p32       = pvalid_r ? {16'b0, pcap_r} : 32'hFFFF_FFFF;
  assign ovf_m1    = ovf_r - 16'd1;
  assign ovf_time  = {16'b0, ovf_m1} * period32;
  assign dur       = (ovf_r != 16'd0) ? (ovf_time + (top32 - p32) + cap32) : (cap32 - p32);
  assign press_gap = gap_r + cap32;
  assign gap_tick  = gap_r + period32;
  assign hold_tick = hold_r + period32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= KS_IDLE;
      gap_r     <= '0;
      hold_r    <= '0;
      pcap_r    <= '0;
      pvalid_r  <= 1'b0;
      ovf_r     <= '0;
      startup_r <= 1'b0;
      click_r   <= '0;
      dbl_r     <= '0;
      lng_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      gap_r     <= gap_nxt;
      hold_r    <= hold_nxt;
      pcap_r    <= pcap_nxt;
      pvalid_r  <= pvalid_nxt;
      ovf_r     <= ovf_nxt;
      startup_r <= startup_nxt;
      click_r   <= click_nxt;
      dbl_r     <= dbl_nxt;
      lng_r     <= lng_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    gap_nxt     = gap_r;
    hold_nxt    = hold_r;
    pcap_nxt    = pcap_r;
    pvalid_nxt  = pvalid_r;
    ovf_nxt     = ovf_r;
    startup_nxt = startup_r;
    click_nxt   = click_r;
    dbl_nxt     = dbl_r;
    lng_nxt     = lng_r;
    if (ev_en) begin
      case (ev_mode)
        MODE_PRESS: begin
          hold_nxt   = cap32;
          pcap_nxt   = ev_cap;
          pvalid_nxt = 1'b1;
          if (state_r == KS_IDLE) begin
            state_nxt = KS_PRESSED;
          end else if (state_r == KS_DCHECK && press_gap < cfg.double_timeout_us) begin
            state_nxt = KS_DCONFIRM;
            gap_nxt   = '0;
          end
        end
        MODE_RELEASE: begin
          if (state_r == KS_PRESSED && dur > cfg.long_timeout_us) begin
            state_nxt = KS_IDLE;
            lng_nxt   = lng_r + 8'd1;
          end else if (state_r == KS_PRESSED && dur < cfg.long_timeout_us) begin
            state_nxt = KS_DCHECK;
            gap_nxt   = top32 - cap32;
          end else if (state_r == KS_DCONFIRM && dur < cfg.long_timeout_us) begin
            state_nxt = KS_IDLE;
            dbl_nxt   = dbl_r + 8'd1;
          end else begin
            state_nxt = KS_IDLE;
          end
          ovf_nxt    = '0;
          pvalid_nxt = 1'b0;
        end
        MODE_TICK: begin
          if (state_r == KS_DCHECK) begin
            gap_nxt = gap_tick;
            if (gap_tick > cfg.double_timeout_us) begin
              state_nxt = KS_IDLE;
              click_nxt = click_r + 8'd1;
              gap_nxt   = '0;
            end
          end else if (state_r == KS_PRESSED) begin
            if (!startup_r) begin
              // The first tick ever seen while pressed drops that press.
              startup_nxt = 1'b1;
              state_nxt   = KS_IDLE;
            end else begin
              hold_nxt = hold_tick;
              if (hold_tick > cfg.long_timeout_us) begin
                hold_nxt  = '0;
                lng_nxt   = lng_r + 8'd1;
                state_nxt = KS_LONG;
              end
            end
          end
          if (pvalid_r) begin
            ovf_nxt = ovf_r + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_nxt.btn_state    = state_nxt;
    res_nxt.click_count  = click_nxt;
    res_nxt.double_count = dbl_nxt;
    res_nxt.long_count   = lng_nxt;
  end

endmodule

@@ rtl/core/key_click_classifier.sv @@
// Key click classifier: sorts key presses into single clicks, double clicks
// and long presses.
// The input channel carries one event per item: tuser holds the event kind
// (press edge, release edge or period tick) and tdata the timer capture.
// Every item, of any kind, yields exactly one result item holding the key
// state after the event and the three 8-bit wrapping event counts.
// An accepted item sits in the input register; its result is then loaded into
// the result register and offered. The throughput is one item per cycle while
// the receiver keeps taking results; the path that sets it is the release
// duration (one 16 by 16 multiply and two adds) feeding the timeout compare
// ahead of the state registers.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; after that in_tready drops until the
// result is taken, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both registers, returns the state
// machine to idle, clears all times and counts and loads the default
// configuration. Configuration writes take effect on the next clock edge and
// are meant to be made while no item is in flight.
module key_click_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] capture
  input  logic [1:0]  in_tuser,    // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [2:0] button state, [10:3] click_count,
                                   // [18:11] double_count, [26:19] long_count, rest zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import kcc_pkg::*;

  `include "key_click_classifier_assert.svh"

  cfg_t        cfg_r;
  logic        s1_valid_r;
  logic [1:0]  s1_mode_r;
  logic [15:0] s1_cap_r;
  logic        out_valid_r;
  result_t     out_data_r;
  result_t     res_nxt;
  logic        adv;
  logic        fire;

  // The result register can take a new item when empty or being emptied.
  assign adv       = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timer_top         <= TIMER_TOP_RST;
      cfg_r.period_us         <= PERIOD_US_RST;
      cfg_r.double_timeout_us <= DOUBLE_TOUT_RST;
      cfg_r.long_timeout_us   <= LONG_TOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMER_TOP:   cfg_r.timer_top         <= cfg_wdata[15:0];
        REG_PERIOD_US:   cfg_r.period_us         <= cfg_wdata[15:0];
        REG_DOUBLE_TOUT: cfg_r.double_timeout_us <= cfg_wdata;
        REG_LONG_TOUT:   cfg_r.long_timeout_us   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_tuser;
      s1_cap_r  <= in_tdata;
    end
  end

  // The classifier updates its state at the edge the item moves to the output.
  kcc_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .ev_en   (fire),
    .ev_mode (s1_mode_r),
    .ev_cap  (s1_cap_r),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        out_data_r <= res_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_data_r};

  // A held item in the input register is not dropped while the output stalls.
  `KCC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !adv, s1_valid_r)
  // The result register changes only when an item moves into it.
  `KCC_ASSERT_NEXT(a_out_stable, clk, rst_n, !fire, $stable(out_data_r))
  // A result only appears after an item sat in the input register.
  `KCC_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid_r), $past(s1_valid_r))

endmodule
